/* hdl/sortq_pkg.sv */
package sortq_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SIZE   = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 16;
    localparam int COUNT_W = 5;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } entry_t;

    typedef struct packed {
        logic                      insert;
        logic                      remove;
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } cell_op_t;

endpackage

/* hdl/sortq_cell.sv */
module sortq_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  sortq_pkg::cell_op_t op,
    input  sortq_pkg::entry_t left_entry,
    input  logic              left_take,
    input  sortq_pkg::entry_t right_entry,
    output sortq_pkg::entry_t entry,
    output logic              take
);
    import sortq_pkg::*;

    logic                      valid_reg, valid_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic signed [PRIO_W-1:0]  prio_reg, prio_next;

    // A cell takes part in an insert when the new priority belongs at or before it.
    assign take = !valid_reg || (op.prio <= prio_reg);

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        prio_next  = prio_reg;
        if (op.insert && take) begin
            if (left_take) begin
                valid_next = left_entry.valid;
                value_next = left_entry.value;
                prio_next  = left_entry.prio;
            end else begin
                valid_next = 1'b1;
                value_next = op.value;
                prio_next  = op.prio;
            end
        end else if (op.remove) begin
            valid_next = right_entry.valid;
            value_next = right_entry.value;
            prio_next  = right_entry.prio;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign entry.valid = valid_reg;
    assign entry.value = value_reg;
    assign entry.prio  = prio_reg;

endmodule

/* hdl/sorted_priority_queue_core.sv */
// Bounded priority queue held as a row of DEPTH cells kept sorted by priority, lowest
// number at the front; among equal priorities the newest entry leaves first. Each word
// carries one command and gives exactly one result word. Every command is applied to
// all cells at once, since all cells compare against the new priority and shift toward a
// neighbor in parallel, so one word is taken per cycle; s_axis_tready drops only while a
// result is held in the output register and not yet taken. An insert into a full queue is
// dropped with status full, a remove from an empty queue reports status empty, and
// commands 2 and 3 act as a size query. entry_count gives the low five bits of the count.
module sorted_priority_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // cmd [1:0], value [33:2], priority_req [49:34], zero padding [55:50]
    input  logic [sortq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // removed_value [31:0], status [33:32], entry_count [38:34], zero padding [39]
    output logic [sortq_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import sortq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                      accept;
    cmd_t                      cmd;
    logic signed [VALUE_W-1:0] in_value;
    logic signed [PRIO_W-1:0]  in_prio;
    logic                      full;
    logic                      empty;
    cell_op_t                  op;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic signed [VALUE_W-1:0] removed;
    status_t                   status;
    logic [31:0]               count_wide;

    entry_t entries [DEPTH];
    logic   takes   [DEPTH];

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign cmd      = cmd_t'(s_axis_tdata[1:0]);
    assign in_value = s_axis_tdata[33:2];
    assign in_prio  = s_axis_tdata[49:34];

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign op.insert = accept && (cmd == CMD_INSERT) && !full;
    assign op.remove = accept && (cmd == CMD_REMOVE) && !empty;
    assign op.value  = in_value;
    assign op.prio   = in_prio;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            entry_t left_entry;
            logic   left_take;
            entry_t right_entry;

            if (i == 0) begin : g_first
                assign left_entry = '0;
                assign left_take  = 1'b0;
            end else begin : g_mid
                assign left_entry = entries[i-1];
                assign left_take  = takes[i-1];
            end

            if (i == DEPTH - 1) begin : g_last
                assign right_entry = '0;
            end else begin : g_inner
                assign right_entry = entries[i+1];
            end

            sortq_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .op          (op),
                .left_entry  (left_entry),
                .left_take   (left_take),
                .right_entry (right_entry),
                .entry       (entries[i]),
                .take        (takes[i])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        removed    = '0;
        status     = ST_OK;
        case (cmd)
            CMD_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    removed    = entries[0].value;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
        count_wide  = 32'(count_next);
        m_data_next = {1'b0, count_wide[COUNT_W-1:0], status, removed};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
